### rtl/core/tss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_pkg: shared types and constants of the thread slot scheduler
// Operation and status codes, configuration indexes, request and result
// words, and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tss_pkg;

  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_YIELD  = 2'd1;
  localparam logic [1:0] OP_EXIT   = 2'd2;
  localparam logic [1:0] OP_START  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_NO_RUN  = 2'd2;

  localparam logic CFG_STACK_BASE   = 1'b0;
  localparam logic CFG_STACK_STRIDE = 1'b1;

  localparam logic [7:0] STACK_BASE_RST   = 8'h3F;
  localparam logic [7:0] STACK_STRIDE_RST = 8'h10;
  localparam logic [7:0] ZERO_BYTE        = 8'h00;

  localparam int         FRAME_BYTES = 7;
  localparam logic [2:0] FRAME_LAST  = 3'(FRAME_BYTES - 1);

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  sp_in;
    logic [15:0] entry_addr;
    logic [1:0]  thread_sel;
  } req_t;

  typedef struct packed {
    logic       write_valid;
    logic [7:0] write_addr;
    logic [7:0] write_data;
    logic [1:0] thread_id;
    logic [7:0] sp_out;
    logic [1:0] status;
    logic       last;
  } res_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic frame_step;
  } dp_cmd_t;

  typedef struct packed {
    logic create_go;
    logic frame_done;
  } dp_sts_t;

endpackage

### rtl/core/tss_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_ctrl: scheduler sequencer
// Accepts a request, runs the execute state and, for a create that finds a
// free slot, steps the datapath through the seven stack frame writes.
// ----------------------------------------------------------------------------
module tss_ctrl
  import tss_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_FRAME = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = sts.create_go ? S_FRAME : S_IDLE;
      end
      S_FRAME: begin
        if (sts.frame_done) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy           = (state != S_IDLE);
  assign cmd.load       = start && (state == S_IDLE);
  assign cmd.exec       = (state == S_EXEC);
  assign cmd.frame_step = (state == S_FRAME);

  a_exec_after_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_EXEC)
    else $error("execute cycle missing after accept");

  a_frame_from_create: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC && sts.create_go |=> state == S_FRAME)
    else $error("create did not enter frame writes");

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cmd.load)
    else $error("load while busy");

endmodule

### rtl/core/tss_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_datapath: slot state, stack frame generator and result register
// Holds valid bits, saved stack pointers, current slot and configuration;
// executes one request per execute command and emits frame bytes per step.
// ----------------------------------------------------------------------------
module tss_datapath
  import tss_pkg::*;
#(
  parameter int NUM_SLOTS = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  req_t       request,
  input  dp_cmd_t    cmd,
  output dp_sts_t    sts,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  output logic       strobe,
  output res_t       result
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic [7:0]           stack_base;
  logic [7:0]           stack_stride;
  logic [NUM_SLOTS-1:0] slot_valid;
  logic [IDX_W-1:0]     current_slot;
  logic [7:0]           saved_sp [NUM_SLOTS];

  req_t                 req;
  logic [IDX_W-1:0]     frame_slot;
  logic [7:0]           ptr;
  logic [2:0]           cnt;

  logic                 have_free;
  logic [IDX_W-1:0]     free_slot;
  logic [NUM_SLOTS-1:0] valid_eff;
  logic                 found;
  logic [IDX_W-1:0]     next_slot;
  logic [IDX_W-1:0]     sel_idx;
  logic                 sel_ok;
  logic [IDX_W-1:0]     rd_idx;
  logic [7:0]           rd_sp;
  logic [7:0]           ptr_start;
  logic [7:0]           ptr_inc;
  logic [7:0]           frame_byte;
  logic                 strobe_next;
  res_t                 result_next;

  always_comb begin
    have_free = 1'b0;
    free_slot = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        have_free = 1'b1;
        free_slot = IDX_W'(i);
      end
    end
  end

  always_comb begin
    int c;
    valid_eff = slot_valid;
    if (req.op == OP_EXIT) valid_eff[current_slot] = 1'b0;
    found     = 1'b0;
    next_slot = current_slot;
    for (int k = NUM_SLOTS; k >= 1; k--) begin
      c = int'(current_slot) + k;
      if (c >= NUM_SLOTS) c = c - NUM_SLOTS;
      if (valid_eff[IDX_W'(c)]) begin
        found     = 1'b1;
        next_slot = IDX_W'(c);
      end
    end
  end

  assign sel_idx   = IDX_W'(req.thread_sel);
  assign sel_ok    = (int'(req.thread_sel) < NUM_SLOTS) && slot_valid[sel_idx];
  assign rd_idx    = (req.op == OP_START) ? sel_idx : next_slot;
  assign rd_sp     = saved_sp[rd_idx];
  assign ptr_start = stack_base + 8'(8'(free_slot) * stack_stride);
  assign ptr_inc   = ptr + 8'd1;

  always_comb begin
    case (cnt)
      3'd0:       frame_byte = req.entry_addr[7:0];
      3'd1:       frame_byte = req.entry_addr[15:8];
      FRAME_LAST: frame_byte = 8'({frame_slot, 3'b000});
      default:    frame_byte = ZERO_BYTE;
    endcase
  end

  assign sts.create_go  = (req.op == OP_CREATE) && have_free;
  assign sts.frame_done = (cnt == FRAME_LAST);

  always_comb begin
    result_next = '0;
    strobe_next = 1'b0;
    if (cmd.exec && !sts.create_go) begin
      strobe_next        = 1'b1;
      result_next.last   = 1'b1;
      result_next.sp_out = req.sp_in;
      case (req.op)
        OP_CREATE: begin
          result_next.status = ST_NO_FREE;
        end
        OP_START: begin
          if (sel_ok) begin
            result_next.thread_id = req.thread_sel;
            result_next.sp_out    = rd_sp;
          end else begin
            result_next.thread_id = 2'(current_slot);
            result_next.status    = ST_NO_RUN;
          end
        end
        default: begin
          if (found) begin
            result_next.thread_id = 2'(next_slot);
            if (!(req.op == OP_YIELD && next_slot == current_slot)) begin
              result_next.sp_out = rd_sp;
            end
          end else begin
            result_next.thread_id = 2'(current_slot);
            result_next.status    = ST_NO_RUN;
          end
        end
      endcase
    end else if (cmd.frame_step) begin
      strobe_next             = 1'b1;
      result_next.write_valid = 1'b1;
      result_next.write_addr  = ptr_inc;
      result_next.write_data  = frame_byte;
      result_next.thread_id   = 2'(frame_slot);
      result_next.sp_out      = req.sp_in;
      result_next.status      = ST_OK;
      result_next.last        = sts.frame_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_base   <= STACK_BASE_RST;
      stack_stride <= STACK_STRIDE_RST;
      slot_valid   <= '0;
      current_slot <= '0;
      strobe       <= 1'b0;
    end else begin
      strobe <= strobe_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_STACK_BASE:   stack_base   <= cfg_data;
          CFG_STACK_STRIDE: stack_stride <= cfg_data;
          default:          stack_base   <= stack_base;
        endcase
      end
      if (cmd.exec) begin
        case (req.op)
          OP_CREATE: begin
            if (have_free) slot_valid[free_slot] <= 1'b1;
          end
          OP_START: begin
            if (sel_ok) current_slot <= sel_idx;
          end
          OP_EXIT: begin
            slot_valid[current_slot] <= 1'b0;
            if (found) current_slot <= next_slot;
          end
          default: begin
            if (found) current_slot <= next_slot;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (cmd.load) req <= request;
    if (cmd.exec) begin
      frame_slot <= free_slot;
      ptr        <= ptr_start;
      cnt        <= '0;
      if (req.op == OP_YIELD) saved_sp[current_slot] <= req.sp_in;
    end
    if (cmd.frame_step) begin
      ptr <= ptr_inc;
      cnt <= cnt + 3'd1;
      if (sts.frame_done) saved_sp[frame_slot] <= ptr_inc;
    end
  end

  a_fail_is_single: assert property (@(posedge clk) disable iff (rst)
    strobe && result.status != ST_OK |-> result.last && !result.write_valid)
    else $error("failed request not a single final word");

  a_current_in_range: assert property (@(posedge clk) disable iff (rst)
    int'(current_slot) < NUM_SLOTS)
    else $error("current slot out of range");

  a_frame_continues: assert property (@(posedge clk) disable iff (rst)
    strobe && result.write_valid && !result.last |=> strobe && result.write_valid)
    else $error("frame write sequence broken");

  a_frame_addr_step: assert property (@(posedge clk) disable iff (rst)
    strobe && result.write_valid && !result.last
      |=> result.write_addr == $past(result.write_addr) + 8'd1)
    else $error("frame address did not advance");

endmodule

### rtl/core/thread_slot_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thread_slot_scheduler_top: round-robin hardware thread slot scheduler
// A request is taken when start is high and busy is low. Yield, exit, start
// and a failed create hold busy for the execute state only and give one
// result word, registered from that state; a create holds busy for the
// execute state and all seven frame steps and gives seven stack write
// words on consecutive cycles, the last of them once busy is low again.
// Every word comes out of the result register. Each word is valid for
// exactly the one cycle its strobe is high; the receiver cannot stall, so it
// must take every word as it comes. Configuration writes belong only to idle
// periods.
// ----------------------------------------------------------------------------
module thread_slot_scheduler_top
  import tss_pkg::*;
#(
  parameter int NUM_SLOTS = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  req_t       request,
  output logic       strobe,
  output res_t       result,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  tss_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  tss_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .strobe    (strobe),
    .result    (result)
  );

endmodule

### tb/tb_thread_slot_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_thread_slot_scheduler_top: self-checking bench for the thread scheduler
// Sends create, yield, exit and start requests with random gaps and bursts.
// The requests run under several stack base and stride layouts, the extremes
// among them. A slot table tracker mirrors the valid bits, saved stack
// pointers and current slot, and checks every result word in order.
// ----------------------------------------------------------------------------
module tb_thread_slot_scheduler_top;
  import tss_pkg::*;

  localparam int SLOTS = 4;

  class slot_table_tracker;
    logic [SLOTS-1:0] valid_slots = '0;
    logic [7:0]       saved_sp [SLOTS];
    logic [1:0]       cur_slot = '0;
    logic [7:0]       base = STACK_BASE_RST;
    logic [7:0]       stride = STACK_STRIDE_RST;
    res_t             due_words [$];
    int               errors = 0;
    int               n_requests = 0;
    int               n_words = 0;
    int               n_created = 0;
    int               n_no_free = 0;
    int               n_no_run = 0;

    function void set_reg(logic idx, logic [7:0] v);
      if (idx == CFG_STACK_BASE) begin
        base = v;
      end else begin
        stride = v;
      end
    endfunction

    function void queue_word(logic wv, logic [7:0] addr, logic [7:0] data,
                             logic [1:0] tid, logic [7:0] sp, logic [1:0] st,
                             logic lst);
      res_t w;
      w.write_valid = wv;
      w.write_addr  = addr;
      w.write_data  = data;
      w.thread_id   = tid;
      w.sp_out      = sp;
      w.status      = st;
      w.last        = lst;
      due_words.push_back(w);
    endfunction

    function void take_request(req_t r);
      int         free_slot;
      int         nxt;
      logic [7:0] ptr;
      logic [7:0] frame [FRAME_BYTES];
      free_slot = -1;
      nxt = -1;
      n_requests++;
      case (r.op)
        OP_CREATE: begin
          for (int s = SLOTS - 1; s >= 0; s--) begin
            if (!valid_slots[s]) free_slot = s;
          end
          if (free_slot < 0) begin
            queue_word(1'b0, ZERO_BYTE, ZERO_BYTE, 2'd0, r.sp_in, ST_NO_FREE, 1'b1);
            n_no_free++;
          end else begin
            valid_slots[free_slot] = 1'b1;
            ptr = base + 8'(free_slot) * stride;
            frame[0] = r.entry_addr[7:0];
            frame[1] = r.entry_addr[15:8];
            for (int k = 2; k < FRAME_BYTES - 1; k++) frame[k] = ZERO_BYTE;
            frame[FRAME_BYTES-1] = 8'(free_slot << 3);
            for (int k = 0; k < FRAME_BYTES; k++) begin
              ptr = ptr + 8'd1;
              queue_word(1'b1, ptr, frame[k], 2'(free_slot), r.sp_in, ST_OK,
                         k == FRAME_BYTES - 1);
            end
            saved_sp[free_slot] = ptr;
            n_created++;
          end
        end
        OP_START: begin
          if (!valid_slots[r.thread_sel]) begin
            queue_word(1'b0, ZERO_BYTE, ZERO_BYTE, cur_slot, r.sp_in, ST_NO_RUN, 1'b1);
            n_no_run++;
          end else begin
            cur_slot = r.thread_sel;
            queue_word(1'b0, ZERO_BYTE, ZERO_BYTE, r.thread_sel, saved_sp[r.thread_sel],
                       ST_OK, 1'b1);
          end
        end
        default: begin
          if (r.op == OP_YIELD) begin
            saved_sp[cur_slot] = r.sp_in;
          end else begin
            valid_slots[cur_slot] = 1'b0;
          end
          for (int k = SLOTS; k >= 1; k--) begin
            if (valid_slots[(int'(cur_slot) + k) % SLOTS]) nxt = (int'(cur_slot) + k) % SLOTS;
          end
          if (nxt < 0) begin
            queue_word(1'b0, ZERO_BYTE, ZERO_BYTE, cur_slot, r.sp_in, ST_NO_RUN, 1'b1);
            n_no_run++;
          end else begin
            cur_slot = 2'(nxt);
            queue_word(1'b0, ZERO_BYTE, ZERO_BYTE, 2'(nxt), saved_sp[nxt], ST_OK, 1'b1);
          end
        end
      endcase
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_word(res_t got);
      res_t want;
      n_words++;
      if (due_words.size() == 0) begin
        $display("%0t ns: result word with none expected, expected none, actual %h",
                 $time, got);
        errors++;
        return;
      end
      want = due_words.pop_front();
      compare("write_valid", want.write_valid, got.write_valid);
      compare("write_addr", want.write_addr, got.write_addr);
      compare("write_data", want.write_data, got.write_data);
      compare("thread_id", want.thread_id, got.thread_id);
      compare("sp_out", want.sp_out, got.sp_out);
      compare("status", want.status, got.status);
      compare("last", want.last, got.last);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  req_t       request = '0;
  logic       strobe;
  res_t       result;
  logic       cfg_we = 1'b0;
  logic       cfg_index = CFG_STACK_BASE;
  logic [7:0] cfg_data = 8'h00;

  slot_table_tracker slot_table;
  int                layouts = 1;

  thread_slot_scheduler_top #(
    .NUM_SLOTS(SLOTS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .strobe(strobe),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && strobe) slot_table.check_word(result);
  end

  function automatic req_t word_of(logic [1:0] op, logic [7:0] sp, logic [15:0] entry,
                                   logic [1:0] sel);
    req_t r;
    r.op = op;
    r.sp_in = sp;
    r.entry_addr = entry;
    r.thread_sel = sel;
    return r;
  endfunction

  function automatic req_t random_word(int create_pct);
    req_t r;
    r.sp_in = 8'($urandom);
    r.entry_addr = 16'($urandom);
    r.thread_sel = 2'($urandom);
    if ($urandom_range(0, 99) < create_pct) begin
      r.op = OP_CREATE;
    end else begin
      case ($urandom_range(0, 2))
        0: r.op = OP_YIELD;
        1: r.op = OP_EXIT;
        default: r.op = OP_START;
      endcase
    end
    return r;
  endfunction

  task automatic send_word(req_t r, int max_gap);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    slot_table.take_request(r);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (slot_table.due_words.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_stack_layout(logic [7:0] b, logic [7:0] s);
    cfg_we <= 1'b1;
    cfg_index <= CFG_STACK_BASE;
    cfg_data <= b;
    @(posedge clk);
    cfg_index <= CFG_STACK_STRIDE;
    cfg_data <= s;
    @(posedge clk);
    cfg_we <= 1'b0;
    slot_table.set_reg(CFG_STACK_BASE, b);
    slot_table.set_reg(CFG_STACK_STRIDE, s);
    layouts++;
    @(posedge clk);
  endtask

  initial begin
    logic [7:0] bases [6];
    logic [7:0] strides [6];
    int         pcts [6];
    int         gaps [6];
    bases = '{8'hFC, 8'h00, 8'hFF, 8'h00, 8'h00, STACK_BASE_RST};
    strides = '{8'hFF, 8'h00, 8'h01, 8'hFF, 8'h00, STACK_STRIDE_RST};
    pcts = '{40, 30, 50, 25, 35, 45};
    gaps = '{11, 11, 0, 11, 11, 11};
    bases[4] = 8'($urandom);
    strides[4] = 8'($urandom);
    pcts[5] = $urandom_range(20, 60);
    gaps[5] = $urandom_range(0, 1) * 11;
    slot_table = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_word(word_of(OP_YIELD, 8'hFF, 16'h0000, 2'd0), 11);
    send_word(word_of(OP_EXIT, 8'h00, 16'hFFFF, 2'd3), 11);
    send_word(word_of(OP_START, 8'h21, 16'h0000, 2'd3), 11);
    send_word(word_of(OP_CREATE, 8'h00, 16'h0000, 2'd0), 11);
    send_word(word_of(OP_CREATE, 8'hFF, 16'hFFFF, 2'd3), 11);
    send_word(word_of(OP_CREATE, 8'hA5, 16'hA55A, 2'd1), 11);
    send_word(word_of(OP_CREATE, 8'h5A, 16'h5AA5, 2'd2), 11);
    send_word(word_of(OP_CREATE, 8'h77, 16'h8001, 2'd0), 11);
    send_word(word_of(OP_START, 8'h12, 16'h0000, 2'd2), 11);
    send_word(word_of(OP_YIELD, 8'hFF, 16'h0000, 2'd0), 11);
    send_word(word_of(OP_YIELD, 8'h00, 16'h0000, 2'd0), 11);
    send_word(word_of(OP_EXIT, 8'h34, 16'h0000, 2'd0), 11);
    send_word(word_of(OP_CREATE, 8'h9C, 16'h1234, 2'd0), 11);
    send_word(word_of(OP_EXIT, 8'h01, 16'h0000, 2'd0), 0);
    send_word(word_of(OP_EXIT, 8'h02, 16'h0000, 2'd0), 0);
    send_word(word_of(OP_EXIT, 8'h03, 16'h0000, 2'd0), 0);
    send_word(word_of(OP_START, 8'h44, 16'h0000, 2'd3), 11);
    send_word(word_of(OP_YIELD, 8'h55, 16'h0000, 2'd0), 11);
    send_word(word_of(OP_EXIT, 8'h66, 16'h0000, 2'd0), 11);
    send_word(word_of(OP_START, 8'h88, 16'h0000, 2'd0), 11);
    drain();
    set_stack_layout(bases[0], strides[0]);
    send_word(word_of(OP_CREATE, 8'hC3, 16'hFFFF, 2'd0), 11);
    send_word(word_of(OP_CREATE, 8'h3C, 16'h00FF, 2'd1), 0);
    send_word(word_of(OP_CREATE, 8'hE1, 16'hFF00, 2'd2), 0);

    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        drain();
        set_stack_layout(bases[p], strides[p]);
      end
      for (int i = 0; i < 75; i++) begin
        send_word(random_word(pcts[p]), gaps[p]);
        if ($urandom_range(0, 39) == 0) drain();
      end
    end
    drain();

    $display("Ran %0d requests giving %0d result words over %0d stack layouts.",
             slot_table.n_requests, slot_table.n_words, layouts);
    $display("Frames built: %0d, full-table creates: %0d, no runnable thread: %0d.",
             slot_table.n_created, slot_table.n_no_free, slot_table.n_no_run);
    if (slot_table.errors == 0 && slot_table.due_words.size() == 0) begin
      $display("PASS thread_slot_scheduler_top");
    end else begin
      $display("FAIL thread_slot_scheduler_top");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL thread_slot_scheduler_top");
    $finish;
  end

endmodule
